// File: src/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 64;
    localparam int COUNT_W  = 7;

    // Operation codes carried on the op field.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // One stored entry: the key and its value handle.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = KEY_W + HANDLE_W;

endpackage

// File: src/lkvc_in_if.sv
// Request channel of the LRU key/value cache: valid, ready and the request fields.
interface lkvc_in_if import lkvc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] value_handle;

    modport source (output valid, output op, output key, output value_handle, input ready);
    modport sink   (input valid, input op, input key, input value_handle, output ready);

endinterface

// File: src/lkvc_out_if.sv
// Response channel of the LRU key/value cache: valid, ready and the result fields.
interface lkvc_out_if import lkvc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output hit, output found_handle, output evicted,
                    output evicted_handle, output entry_count, input ready);
    modport sink   (input valid, input hit, input found_handle, input evicted,
                    input evicted_handle, input entry_count, output ready);

endinterface

// File: src/lkvc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module lkvc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key/value cache core.
//
// Entries are held in one RAM in recency order, most recently used at address 0, and a
// small sequencer walks that RAM one address per cycle through its single read and single
// write port; the block takes one request at a time and drops ready until the result is
// in the output register. A zero key, or a lookup on an empty cache, goes straight to the
// result. A lookup scans from address 0 and reads one entry a cycle; on a hit the entries
// above the match then move down one place each and the match is written to address 0.
// An insert moves every stored entry down one place and writes the new entry to address 0;
// when the cache is full the least recently used entry is read out first and evicted.
// The next request is taken while a result still waits at the response channel. The RAM
// needs no clearing after reset, since only the first entry_count addresses are ever read.
module lru_key_value_cache_core import lkvc_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    lkvc_in_if.sink     request,
    lkvc_out_if.source  response
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_EVICT = 6'b000100,
        S_SHIFT = 6'b001000,
        S_FRONT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    entry_t              entry_reg, entry_next;
    logic                hit_reg, hit_next;
    logic [HANDLE_W-1:0] found_reg, found_next;
    logic                ev_reg, ev_next;
    logic [HANDLE_W-1:0] evh_reg, evh_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;
    logic [HANDLE_W-1:0] out_found_reg, out_found_next;
    logic                out_ev_reg, out_ev_next;
    logic [HANDLE_W-1:0] out_evh_reg, out_evh_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    entry_t              ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    entry_t              ram_rd_data;

    logic [CW+COUNT_W-1:0] count_wide;
    logic                  cache_full;

    // Entry storage in recency order.
    lkvc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The count field shows the low bits of the entry count.
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};
    assign cache_full = (count_reg == CW'(CAPACITY));

    assign request.ready           = (state_reg == S_IDLE);
    assign response.valid          = out_valid_reg;
    assign response.hit            = out_hit_reg;
    assign response.found_handle   = out_found_reg;
    assign response.evicted        = out_ev_reg;
    assign response.evicted_handle = out_evh_reg;
    assign response.entry_count    = out_count_reg;

    // Sequencer and RAM control.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        entry_next     = entry_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        ev_next        = ev_reg;
        evh_next       = evh_reg;
        out_valid_next = out_valid_reg && !response.ready;
        out_hit_next   = out_hit_reg;
        out_found_next = out_found_reg;
        out_ev_next    = out_ev_reg;
        out_evh_next   = out_evh_reg;
        out_count_next = out_count_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = entry_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    key_next         = request.key;
                    entry_next.key    = request.key;
                    entry_next.handle = request.value_handle;
                    hit_next         = 1'b0;
                    found_next       = '0;
                    ev_next          = 1'b0;
                    evh_next         = '0;
                    if (request.key == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (request.op == OP_INSERT)
                    begin
                        if (cache_full)
                        begin
                            // Read the least recently used entry for eviction.
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = AW'(CAPACITY - 1);
                            state_next  = S_EVICT;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                state_next = S_FRONT;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(count_reg - CW'(1));
                                ptr_next    = AW'(count_reg - CW'(1));
                                state_next  = S_SHIFT;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            ptr_next    = '0;
                            state_next  = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Compare the entry read last cycle while the next read goes out.
                if (ram_rd_data.key == key_reg)
                begin
                    hit_next   = 1'b1;
                    found_next = ram_rd_data.handle;
                    entry_next = ram_rd_data;
                    if (ptr_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ptr_reg - AW'(1);
                        ptr_next    = ptr_reg - AW'(1);
                        state_next  = S_SHIFT;
                    end
                end
                else if (CW'(ptr_reg) + CW'(1) == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg + AW'(1);
                    ptr_next    = ptr_reg + AW'(1);
                end
            end

            S_EVICT:
            begin
                ev_next  = 1'b1;
                evh_next = ram_rd_data.handle;
                if (CAPACITY == 1)
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(CAPACITY - 2);
                    ptr_next    = AW'(CAPACITY - 2);
                    state_next  = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Move the entry read last cycle one place toward the LRU end.
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg + AW'(1);
                ram_wr_data = ram_rd_data;
                if (ptr_reg == '0)
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg - AW'(1);
                    ptr_next    = ptr_reg - AW'(1);
                end
            end

            S_FRONT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = entry_reg;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                // Load the output register once the previous result has been taken.
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_found_next = found_reg;
                    out_ev_next    = ev_reg;
                    out_evh_next   = evh_reg;
                    out_count_next = count_wide[COUNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        key_reg       <= key_next;
        entry_reg     <= entry_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
        ev_reg        <= ev_next;
        evh_reg       <= evh_next;
        out_hit_reg   <= out_hit_next;
        out_found_reg <= out_found_next;
        out_ev_reg    <= out_ev_next;
        out_evh_reg   <= out_evh_next;
        out_count_reg <= out_count_next;
    end

endmodule

// File: src/lkvc_checker.sv
// Port-level checker for the LRU key/value cache core and its bind to the top level.
module lkvc_checker import lkvc_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                hit,
    input logic [HANDLE_W-1:0] found_handle,
    input logic                evicted,
    input logic [HANDLE_W-1:0] evicted_handle,
    input logic [COUNT_W-1:0]  entry_count
);

    // A stalled result keeps its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({hit, found_handle, evicted, evicted_handle, entry_count}))
    else $error("result changed while stalled");

    // The core is busy in the cycle after a request transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

    // A result is either a lookup or an insert, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
    else $error("hit and eviction in one result");

    // Handles read zero unless their flag is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit || found_handle == '0) && (evicted || evicted_handle == '0))
    else $error("handle without its flag");

    // An eviction only happens with the cache full.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> entry_count == COUNT_W'(CAPACITY))
    else $error("eviction below capacity");

endmodule

bind lru_key_value_cache_core lkvc_checker #(
    .CAPACITY (CAPACITY)
) u_lkvc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (request.valid),
    .in_ready       (request.ready),
    .out_valid      (response.valid),
    .out_ready      (response.ready),
    .hit            (response.hit),
    .found_handle   (response.found_handle),
    .evicted        (response.evicted),
    .evicted_handle (response.evicted_handle),
    .entry_count    (response.entry_count)
);

// File: verif/tb.sv
// Self-checking testbench for the LRU key/value cache core.
`timescale 1ns / 100ps

module tb;
    import lkvc_pkg::*;

    localparam int CACHE_DEPTH = 64;
    localparam int KEY_POOL    = 96;
    localparam int DRAIN_WAIT  = 2 * CACHE_DEPTH + 16;

    typedef struct packed {
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] value_handle;
    } cache_req_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] found_handle;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
        logic [COUNT_W-1:0]  entry_count;
    } cache_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lkvc_in_if  req_if ();
    lkvc_out_if rsp_if ();

    lru_key_value_cache_core #(.CAPACITY(CACHE_DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    // Shadow copy of the cache contents, recency order and occupancy.
    logic [KEY_W-1:0]    shadow_key    [CACHE_DEPTH];
    logic [HANDLE_W-1:0] shadow_handle [CACHE_DEPTH];
    int                  recency       [CACHE_DEPTH];
    int                  live_count;

    cache_req_t    pending_requests [$];
    cache_result_t expected_results [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    cache_req_t next_req;
    int         send_hold;
    int         stall_hold;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         quiet_tail;
    int         mismatches;

    always #5 clk = ~clk;

    // Move the slot at recency position pos to the most recently used end.
    function automatic void promote(int pos);
        int slot;
        slot = recency[pos];
        for (int i = pos; i > 0; i--)
            recency[i] = recency[i - 1];
        recency[0] = slot;
    endfunction

    // Apply one request to the shadow cache and return the response it must produce.
    function automatic cache_result_t apply_request(logic op, logic [KEY_W-1:0] key,
                                                    logic [HANDLE_W-1:0] handle);
        cache_result_t res;
        int            pos;
        int            slot;
        bit            found;
        res = '0;
        if (key != '0)
        begin
            if (op == OP_INSERT)
            begin
                if (live_count >= CACHE_DEPTH)
                begin
                    // Full: the least recently used entry goes and its slot is reused.
                    pos = CACHE_DEPTH - 1;
                    res.evicted = 1'b1;
                    res.evicted_handle = shadow_handle[recency[pos]];
                    live_count = CACHE_DEPTH - 1;
                end
                else
                    pos = live_count;
                slot = recency[pos];
                shadow_key[slot] = key;
                shadow_handle[slot] = handle;
                promote(pos);
                live_count++;
            end
            else
            begin
                // Scan from most to least recently used; the first match wins.
                found = 1'b0;
                for (int i = 0; i < live_count && !found; i++)
                begin
                    if (shadow_key[recency[i]] == key)
                    begin
                        found = 1'b1;
                        res.hit = 1'b1;
                        res.found_handle = shadow_handle[recency[i]];
                        promote(i);
                    end
                end
            end
        end
        res.entry_count = live_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    // Mostly keys from a shared pool so that hits and duplicates are common.
    function automatic cache_req_t random_request(int insert_pct);
        cache_req_t r;
        int         roll;
        roll = $urandom_range(0, 99);
        r.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
        r.value_handle = {$urandom, $urandom};
        if (roll < 5)
            r.key = '0;
        else if (roll < 12)
            r.key = {$urandom, $urandom};
        else
            r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        return r;
    endfunction

    task automatic queue_random(int count, int insert_pct);
        @(negedge clk);
        repeat (count)
            pending_requests.push_back(random_request(insert_pct));
    endtask

    task automatic queue_request(logic op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
        cache_req_t r;
        r.op = op;
        r.key = key;
        r.value_handle = handle;
        pending_requests.push_back(r);
    endtask

    // Hold the sender until every request is taken and every response is back.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Request driver: the shadow cache is updated on each accepted transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid        <= 1'b0;
            req_if.op           <= OP_LOOKUP;
            req_if.key          <= '0;
            req_if.value_handle <= '0;
            send_hold           <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                expected_results.push_back(
                    apply_request(req_if.op, req_if.key, req_if.value_handle));
            if (!req_if.valid || req_if.ready)
            begin
                if (send_hold > 0)
                begin
                    send_hold    <= send_hold - 1;
                    req_if.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0 && !quiet_tail &&
                         $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_hold    <= $urandom_range(0, 6);
                    req_if.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req = pending_requests.pop_front();
                    req_if.op           <= next_req.op;
                    req_if.key          <= next_req.key;
                    req_if.value_handle <= next_req.value_handle;
                    req_if.valid        <= 1'b1;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Response monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_hold   <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Response transfer with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    cache_result_t want;
                    want = expected_results.pop_front();
                    check_field("hit", 64'(want.hit), 64'(rsp_if.hit));
                    check_field("found_handle", want.found_handle, rsp_if.found_handle);
                    check_field("evicted", 64'(want.evicted), 64'(rsp_if.evicted));
                    check_field("evicted_handle", want.evicted_handle, rsp_if.evicted_handle);
                    check_field("entry_count", 64'(want.entry_count),
                                64'(rsp_if.entry_count));
                end
            end
            if (stall_hold > 0)
            begin
                stall_hold   <= stall_hold - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_hold   <= $urandom_range(0, 6);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.op           = OP_LOOKUP;
        req_if.key          = '0;
        req_if.value_handle = '0;
        rsp_if.ready        = 1'b0;
        mismatches          = 0;
        quiet_tail          = 1'b0;
        send_idle_pct       = 15;
        recv_idle_pct       = 15;
        for (int i = 0; i < CACHE_DEPTH; i++)
        begin
            shadow_key[i]    = '0;
            shadow_handle[i] = '0;
            recency[i]       = i;
        end
        live_count = 0;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            if (key_pool[i] == '0)
                key_pool[i] = 64'd1;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero keys, misses on an empty cache, extreme keys and handles,
        // duplicate keys, and hits at several recency positions.
        queue_request(OP_LOOKUP, '0, '0);
        queue_request(OP_INSERT, '0, '1);
        queue_request(OP_LOOKUP, 64'd1, '0);
        queue_request(OP_INSERT, '1, '1);
        queue_request(OP_INSERT, 64'd1, '0);
        queue_request(OP_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        queue_request(OP_INSERT, 64'd1, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(OP_LOOKUP, 64'd1, '1);
        queue_request(OP_LOOKUP, '1, '0);
        queue_request(OP_LOOKUP, 64'h8000_0000_0000_0000, '0);
        queue_request(OP_LOOKUP, 64'd2, '0);
        queue_request(OP_INSERT, '0, 64'h1234_5678_9ABC_DEF0);
        queue_request(OP_LOOKUP, '0, '1);
        queue_request(OP_LOOKUP, 64'd1, '0);
        wait_drained();

        // Insert-heavy traffic fills the cache and drives it into eviction.
        queue_random(450, 65);
        wait_drained();

        // Lookup-heavy traffic with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(400, 35);

        // Heavy idling on both sides.
        wait_drained();
        send_idle_pct = 40;
        recv_idle_pct = 40;
        queue_random(350, 50);
        wait_drained();

        // Closing stretch at full rate.
        quiet_tail = 1'b1;
        queue_random(150, 50);
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/lkvc_pkg.sv
src/lkvc_in_if.sv
src/lkvc_out_if.sv
src/lkvc_ram.sv
src/lru_key_value_cache_core.sv
src/lkvc_checker.sv
verif/tb.sv
